// ===== src/bpe_pkg.sv =====
// Shared widths, pipeline word types and lane indexes for the stereo bin pan estimator.
package bpe_pkg;

    // Square root chain: one result bit per cell, four lanes per cell
    localparam int SQ_LANES  = 4;
    localparam int SQ_RAD_W  = 64;
    localparam int SQ_ROOT_W = 32;
    localparam int SQ_REM_W  = 36;
    localparam int SQ_STEPS  = SQ_ROOT_W;

    localparam int LN_L   = 0;
    localparam int LN_R   = 1;
    localparam int LN_SUM = 2;
    localparam int LN_DIF = 3;

    // Divider chain: one quotient bit per cell, three lanes per cell
    localparam int DV_LANES = 3;
    localparam int DV_NUM_W = 62;
    localparam int DV_DEN_W = 34;
    localparam int DV_REM_W = DV_DEN_W + 1;
    localparam int DV_STEPS = DV_NUM_W;

    localparam int DV_PAN  = 0;
    localparam int DV_PROJ = 1;
    localparam int DV_RAT  = 2;

    // Projection cases
    localparam logic [1:0] K_NEG    = 2'd0;
    localparam logic [1:0] K_MID    = 2'd1;
    localparam logic [1:0] K_HIGH   = 2'd2;
    localparam logic [1:0] K_SILENT = 2'd3;

    typedef struct packed {
        logic [31:0]        pl;
        logic [31:0]        pr;
        logic signed [32:0] ip;
        logic signed [32:0] cr;
        logic               last;
    } sq_side_t;

    typedef struct packed {
        logic [SQ_RAD_W-1:0]  rad;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_REM_W-1:0]  rem;
    } sq_lane_t;

    typedef struct packed {
        logic                    vld;
        sq_side_t                side;
        sq_lane_t [SQ_LANES-1:0] lane;
    } sq_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        left_weak;
        logic        rat_neg;
        logic        sum_zero;
        logic [31:0] mw;
        logic [31:0] mdif;
        logic [31:0] pl;
        logic [31:0] pr;
        logic        last;
    } dv_side_t;

    typedef struct packed {
        logic [DV_NUM_W-1:0] num;
        logic [DV_DEN_W-1:0] den;
        logic [DV_REM_W-1:0] rem;
    } dv_lane_t;

    typedef struct packed {
        logic                    vld;
        dv_side_t                side;
        dv_lane_t [DV_LANES-1:0] lane;
    } dv_word_t;

endpackage

// ===== src/bpe_if.sv =====
// Handshake channels: input bin word and estimate result word.
interface bpe_bin_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_re;
    logic signed [15:0] left_im;
    logic signed [15:0] right_re;
    logic signed [15:0] right_im;
    logic               last_bin;

    modport source (output valid, left_re, left_im, right_re, right_im, last_bin,
                    input ready);
    modport sink   (input valid, left_re, left_im, right_re, right_im, last_bin,
                    output ready);
endinterface

interface bpe_est_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pan;
    logic signed [25:0] pan_amp;
    logic [31:0]        power_left;
    logic [31:0]        power_right;
    logic               last_out;

    modport source (output valid, pan, pan_amp, power_left, power_right, last_out,
                    input ready);
    modport sink   (input valid, pan, pan_amp, power_left, power_right, last_out,
                    output ready);
endinterface

// ===== src/stereo_bin_pan_estimator.sv =====
// Top level of the stereo bin pan estimator: products, root chain, divider chain, result.
//
//   channel | direction | word contents
//   --------+-----------+-----------------------------------------------------
//   bin     | in        | left_re, left_im, right_re, right_im, last_bin
//   est     | out       | pan, pan_amp, power_left, power_right, last_out
//
// One bin word enters per cycle and one estimate leaves per cycle. The chain is
// a product stage, 32 root cells (one root bit each, four magnitudes in
// parallel), a setup stage, 62 divider cells (one quotient bit each, three
// quotients in parallel) and the output register.
// Reset clears the valid bit of every stage; no clearing pass is needed.
// When the output word is held by a stalled sink, the whole chain holds and
// bin.ready drops; otherwise every stage advances each cycle.
module stereo_bin_pan_estimator (
    input  logic      clk,
    input  logic      rst_n,
    bpe_bin_if.sink   bin,
    bpe_est_if.source est
);
    import bpe_pkg::*;

    localparam logic [25:0] AMP_MAX = 26'h1FFFFFF;
    localparam logic [25:0] AMP_MIN = 26'h2000000;

    // Saturate a signed magnitude into the 26-bit amplitude range
    function automatic logic [25:0] sat_amp(input logic neg, input logic [DV_NUM_W-1:0] mag);
        logic [25:0] res;
        if (!neg)
            res = (mag[DV_NUM_W-1:25] != '0) ? AMP_MAX : mag[25:0];
        else if ((mag[DV_NUM_W-1:26] != '0) || (mag[25] && (mag[24:0] != '0)))
            res = AMP_MIN;
        else
            res = 26'(-mag[25:0]);
        return res;
    endfunction

    logic adv;

    // ---------------------------------------------------------------- products
    logic signed [31:0] m_ll, m_li, m_rr, m_ri, m_x1, m_x2, m_c1, m_c2;
    logic signed [16:0] s_re, s_im, d_re, d_im;
    logic signed [33:0] m_sr, m_si, m_dr, m_di;
    logic [31:0]        pl_c, pr_c;
    logic [33:0]        psum_c, pdif_c;
    sq_word_t           sq [SQ_STEPS+1];
    sq_word_t           front_reg;
    sq_word_t           front_next;

    always_comb
    begin
        m_ll = bin.left_re * bin.left_re;
        m_li = bin.left_im * bin.left_im;
        m_rr = bin.right_re * bin.right_re;
        m_ri = bin.right_im * bin.right_im;
        m_x1 = bin.left_re * bin.right_re;
        m_x2 = bin.left_im * bin.right_im;
        m_c1 = bin.left_re * bin.right_im;
        m_c2 = bin.left_im * bin.right_re;
        s_re = 17'(bin.left_re) + 17'(bin.right_re);
        s_im = 17'(bin.left_im) + 17'(bin.right_im);
        d_re = 17'(bin.left_re) - 17'(bin.right_re);
        d_im = 17'(bin.left_im) - 17'(bin.right_im);
        m_sr = s_re * s_re;
        m_si = s_im * s_im;
        m_dr = d_re * d_re;
        m_di = d_im * d_im;
        pl_c   = $unsigned(m_ll) + $unsigned(m_li);
        pr_c   = $unsigned(m_rr) + $unsigned(m_ri);
        psum_c = $unsigned(m_sr) + $unsigned(m_si);
        pdif_c = $unsigned(m_dr) + $unsigned(m_di);

        front_next.vld       = bin.valid;
        front_next.side.pl   = pl_c;
        front_next.side.pr   = pr_c;
        front_next.side.ip   = 33'(m_x1) + 33'(m_x2);
        front_next.side.cr   = 33'(m_c1) - 33'(m_c2);
        front_next.side.last = bin.last_bin;
        // radicands are power << 30 so the roots come out in Q.15
        front_next.lane[LN_L].rad   = {2'b00, pl_c, 30'd0};
        front_next.lane[LN_R].rad   = {2'b00, pr_c, 30'd0};
        front_next.lane[LN_SUM].rad = {psum_c, 30'd0};
        front_next.lane[LN_DIF].rad = {pdif_c, 30'd0};
        for (int k = 0; k < SQ_LANES; k++)
        begin
            front_next.lane[k].root = '0;
            front_next.lane[k].rem  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_reg.vld <= 1'b0;
        else if (adv)
            front_reg <= front_next;
    end

    assign sq[0] = front_reg;

    // -------------------------------------------------------------- root chain
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sq
        bpe_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d     (sq[i]),
            .q     (sq[i+1])
        );
    end

    // ------------------------------------------------------------------- setup
    sq_word_t    sq_o;
    logic        left_weak;
    logic [31:0] ps, mw, ms, m_sum, m_dif, ip_u, ps_dif, acr;
    logic [32:0] d_pan, acr_w, x_rat, ax_rat;
    logic [47:0] num_pan;
    logic [41:0] num_rat;
    dv_word_t    dv [DV_STEPS+1];
    dv_word_t    setup_reg;
    dv_word_t    setup_next;

    always_comb
    begin
        sq_o      = sq[SQ_STEPS];
        left_weak = sq_o.side.pl < sq_o.side.pr;
        ps        = left_weak ? sq_o.side.pr : sq_o.side.pl;
        mw        = left_weak ? sq_o.lane[LN_L].root : sq_o.lane[LN_R].root;
        ms        = left_weak ? sq_o.lane[LN_R].root : sq_o.lane[LN_L].root;
        m_sum     = sq_o.lane[LN_SUM].root;
        m_dif     = sq_o.lane[LN_DIF].root;
        ip_u      = sq_o.side.ip[31:0];

        // pan magnitude: round((ps - ip) * 32768 / (ps + ip))
        d_pan   = {1'b0, ps} + {1'b0, ip_u};
        ps_dif  = ps - ip_u;
        num_pan = {ps_dif, 16'd0} + 48'(d_pan);

        // projection of the cross product onto the stronger magnitude
        acr_w = sq_o.side.cr[32] ? 33'(-sq_o.side.cr) : 33'(sq_o.side.cr);
        acr   = acr_w[31:0];

        // ratio amplitude: round((|L-R| - |w|) * 256 / |L+R|)
        x_rat   = {1'b0, m_dif} - {1'b0, mw};
        ax_rat  = x_rat[32] ? -x_rat : x_rat;
        num_rat = {1'b0, ax_rat[31:0], 9'd0} + 42'(m_sum);

        setup_next.vld            = sq_o.vld;
        setup_next.side.left_weak = left_weak;
        setup_next.side.rat_neg   = x_rat[32];
        setup_next.side.sum_zero  = (m_sum == '0);
        setup_next.side.mw        = mw;
        setup_next.side.mdif      = m_dif;
        setup_next.side.pl        = sq_o.side.pl;
        setup_next.side.pr        = sq_o.side.pr;
        setup_next.side.last      = sq_o.side.last;
        if (sq_o.side.ip[32])
            setup_next.side.kind = K_NEG;
        else if (ip_u <= ps)
            setup_next.side.kind = (ps == '0) ? K_SILENT : K_MID;
        else
            setup_next.side.kind = K_HIGH;

        setup_next.lane[DV_PAN].num  = DV_NUM_W'(num_pan);
        setup_next.lane[DV_PAN].den  = DV_DEN_W'({d_pan, 1'b0});
        setup_next.lane[DV_PROJ].num = {acr, 30'd0};
        setup_next.lane[DV_PROJ].den = DV_DEN_W'(ms);
        setup_next.lane[DV_RAT].num  = DV_NUM_W'(num_rat);
        setup_next.lane[DV_RAT].den  = DV_DEN_W'({m_sum, 1'b0});
        for (int k = 0; k < DV_LANES; k++)
            setup_next.lane[k].rem = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_reg.vld <= 1'b0;
        else if (adv)
            setup_reg <= setup_next;
    end

    assign dv[0] = setup_reg;

    // ----------------------------------------------------------- divider chain
    for (genvar i = 0; i < DV_STEPS; i++)
    begin : g_dv
        bpe_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d     (dv[i]),
            .q     (dv[i+1])
        );
    end

    // ------------------------------------------------------------------ result
    dv_word_t           dv_o;
    logic [16:0]        pan_mag;
    logic [31:0]        big;
    logic [33:0]        x_amp, ax_amp;
    logic [34:0]        rnd;
    logic [27:0]        q_amp;
    logic signed [15:0] pan_c;
    logic [25:0]        amp_c;

    logic               out_vld_reg;
    logic signed [15:0] pan_reg;
    logic [25:0]        amp_reg;
    logic [31:0]        pl_reg, pr_reg;
    logic               last_reg;

    always_comb
    begin
        dv_o    = dv[DV_STEPS];
        pan_mag = dv_o.lane[DV_PAN].num[16:0];
        big     = (dv_o.side.mw > dv_o.side.mdif) ? dv_o.side.mw : dv_o.side.mdif;
        if (dv_o.side.kind == K_MID)
            x_amp = {2'b00, big} - {1'b0, dv_o.lane[DV_PROJ].num[32:0]};
        else
            x_amp = {2'b00, dv_o.side.mw} - {2'b00, dv_o.side.mdif};
        // Q.15 to Q.8, ties away from zero
        ax_amp = x_amp[33] ? -x_amp : x_amp;
        rnd    = {1'b0, ax_amp} + 35'd64;
        q_amp  = rnd[34:7];

        unique case (dv_o.side.kind)
            K_NEG:
            begin
                pan_c = dv_o.side.left_weak ? 16'sd32767 : -16'sd32768;
                amp_c = dv_o.side.sum_zero ? '0
                      : sat_amp(dv_o.side.rat_neg, dv_o.lane[DV_RAT].num);
            end
            K_MID:
            begin
                if (dv_o.side.left_weak)
                    pan_c = pan_mag[15] ? 16'sd32767 : $signed(pan_mag[15:0]);
                else
                    pan_c = $signed(16'(-pan_mag));
                amp_c = sat_amp(x_amp[33], DV_NUM_W'(q_amp));
            end
            K_HIGH:
            begin
                pan_c = '0;
                amp_c = sat_amp(x_amp[33], DV_NUM_W'(q_amp));
            end
            default:
            begin
                pan_c = '0;
                amp_c = '0;
            end
        endcase
    end

    // hold the word while the sink stalls; otherwise advance the whole chain
    assign adv = !out_vld_reg || est.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= dv_o.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pan_reg  <= pan_c;
            amp_reg  <= amp_c;
            pl_reg   <= dv_o.side.pl;
            pr_reg   <= dv_o.side.pr;
            last_reg <= dv_o.side.last;
        end
    end

    assign bin.ready       = adv;
    assign est.valid       = out_vld_reg;
    assign est.pan         = pan_reg;
    assign est.pan_amp     = $signed(amp_reg);
    assign est.power_left  = pl_reg;
    assign est.power_right = pr_reg;
    assign est.last_out    = last_reg;

endmodule

// ===== src/bpe_sqrt_cell.sv =====
// One cell of the square root chain: one root bit for each of four lanes.
module bpe_sqrt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  bpe_pkg::sq_word_t d,
    output bpe_pkg::sq_word_t q
);
    import bpe_pkg::*;

    sq_word_t            q_reg;
    sq_word_t            q_next;
    logic [SQ_REM_W-1:0] rem_sh [SQ_LANES];
    logic [SQ_REM_W-1:0] trial  [SQ_LANES];

    always_comb
    begin
        q_next.vld  = d.vld;
        q_next.side = d.side;
        for (int k = 0; k < SQ_LANES; k++)
        begin
            // bring down the next two radicand bits
            rem_sh[k] = {d.lane[k].rem[SQ_REM_W-3:0], d.lane[k].rad[SQ_RAD_W-1 -: 2]};
            trial[k]  = SQ_REM_W'({d.lane[k].root, 2'b01});
            q_next.lane[k].rad = {d.lane[k].rad[SQ_RAD_W-3:0], 2'b00};
            if (rem_sh[k] >= trial[k])
            begin
                q_next.lane[k].rem  = rem_sh[k] - trial[k];
                q_next.lane[k].root = {d.lane[k].root[SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                q_next.lane[k].rem  = rem_sh[k];
                q_next.lane[k].root = {d.lane[k].root[SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg.vld <= 1'b0;
        else if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== src/bpe_div_cell.sv =====
// One cell of the divider chain: one quotient bit for each of three lanes.
module bpe_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  bpe_pkg::dv_word_t d,
    output bpe_pkg::dv_word_t q
);
    import bpe_pkg::*;

    dv_word_t            q_reg;
    dv_word_t            q_next;
    logic [DV_REM_W-1:0] rem_sh [DV_LANES];
    logic [DV_REM_W-1:0] den_x  [DV_LANES];

    always_comb
    begin
        q_next.vld  = d.vld;
        q_next.side = d.side;
        for (int k = 0; k < DV_LANES; k++)
        begin
            // shift the next dividend bit in; quotient bits enter at the bottom
            rem_sh[k] = {d.lane[k].rem[DV_REM_W-2:0], d.lane[k].num[DV_NUM_W-1]};
            den_x[k]  = DV_REM_W'(d.lane[k].den);
            q_next.lane[k].den = d.lane[k].den;
            if (rem_sh[k] >= den_x[k])
            begin
                q_next.lane[k].rem = rem_sh[k] - den_x[k];
                q_next.lane[k].num = {d.lane[k].num[DV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                q_next.lane[k].rem = rem_sh[k];
                q_next.lane[k].num = {d.lane[k].num[DV_NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg.vld <= 1'b0;
        else if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== sim/tb.sv =====
// Testbench for the stereo bin pan estimator: random bins, self-checking predictor.
`timescale 1ns / 1ps

module tb;
    import bpe_pkg::*;

    localparam int N_RANDOM    = 1850;
    localparam int PIPE_DEPTH  = 97;
    localparam int CALM_TAIL   = 200;   // last words of the run go without idling
    localparam int LONG_STALL  = 300;
    localparam int STALL_AFTER = 150;   // accepted words before the long sink stall

    localparam longint AMP_MAX = 64'sd33554431;
    localparam longint AMP_MIN = -64'sd33554432;

    typedef struct {
        logic signed [15:0] left_re;
        logic signed [15:0] left_im;
        logic signed [15:0] right_re;
        logic signed [15:0] right_im;
        logic               last_bin;
    } bin_word_t;

    typedef struct {
        logic signed [15:0] pan;
        logic signed [25:0] pan_amp;
        logic [31:0]        power_left;
        logic [31:0]        power_right;
        logic               last_out;
    } est_word_t;

    logic clk = 1'b0;
    logic rst_n;

    bpe_bin_if bin_ch ();
    bpe_est_if est_ch ();

    stereo_bin_pan_estimator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .bin   (bin_ch),
        .est   (est_ch)
    );

    always #5 clk = ~clk;

    bin_word_t pending_bins[$];
    est_word_t expected_ests[$];
    int        errors     = 0;
    int        n_accepted = 0;
    logic      bin_fire   = 1'b0;
    logic      long_hold  = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Floor square root of a 64-bit value, one result bit per step.
    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Magnitude of a complex value in Q.15: floor(sqrt(re^2 + im^2) * 2^15).
    function automatic longint mag_q15(longint re, longint im);
        logic [63:0] p;
        p = re * re + im * im;
        return longint'(root_floor(p << 30));
    endfunction

    // Quotient rounded to nearest, ties away from zero; d is positive.
    function automatic longint round_div(longint n, longint d);
        longint an;
        longint q;
        an = (n < 0) ? -n : n;
        q  = (an * 2 + d) / (d * 2);
        return (n < 0) ? -q : q;
    endfunction

    function automatic est_word_t predict_estimate(bin_word_t b);
        longint    lr, li, rr, ri;
        longint    pl, pr, ip, cr, acr;
        longint    m_l, m_r, m_sum, m_dif;
        longint    ps, mw, ms, pan, amp, mag, proj, big;
        logic      left_weak;
        est_word_t e;
        lr = b.left_re;
        li = b.left_im;
        rr = b.right_re;
        ri = b.right_im;
        pl = lr * lr + li * li;
        pr = rr * rr + ri * ri;
        ip = lr * rr + li * ri;
        cr = lr * ri - li * rr;
        m_l   = mag_q15(lr, li);
        m_r   = mag_q15(rr, ri);
        m_sum = mag_q15(lr + rr, li + ri);
        m_dif = mag_q15(lr - rr, li - ri);
        left_weak = pl < pr;
        ps = left_weak ? pr : pl;
        mw = left_weak ? m_l : m_r;
        ms = left_weak ? m_r : m_l;

        if (ip < 0)
        begin
            // Weaker channel points away: full pan, plain ratio amplitude.
            pan = left_weak ? 32767 : -32768;
            amp = (m_sum == 0) ? 0 : round_div((m_dif - mw) * 256, m_sum);
        end
        else if (ip <= ps)
        begin
            if (ps == 0)
            begin
                pan = 0;
                amp = 0;
            end
            else
            begin
                mag = round_div((ps - ip) * 32768, ps + ip);
                pan = left_weak ? mag : -mag;
                if (pan > 32767)
                    pan = 32767;
                acr  = (cr < 0) ? -cr : cr;
                proj = (acr << 30) / ms;
                big  = (mw > m_dif) ? mw : m_dif;
                amp  = round_div(big - proj, 128);
            end
        end
        else
        begin
            pan = 0;
            amp = round_div(mw - m_dif, 128);
        end

        if (amp > AMP_MAX)
            amp = AMP_MAX;
        if (amp < AMP_MIN)
            amp = AMP_MIN;

        e.pan         = pan[15:0];
        e.pan_amp     = amp[25:0];
        e.power_left  = pl[31:0];
        e.power_right = pr[31:0];
        e.last_out    = b.last_bin;
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic bin_word_t make_bin(int lre, int lim, int rre, int rim, bit last);
        bin_word_t b;
        b.left_re  = lre[15:0];
        b.left_im  = lim[15:0];
        b.right_re = rre[15:0];
        b.right_im = rim[15:0];
        b.last_bin = last;
        return b;
    endfunction

    // Append a bin word to the driver's queue.
    function automatic void enqueue_bin(bin_word_t b);
        pending_bins = {pending_bins, b};
    endfunction

    function automatic int rand_s16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int rand_near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // Random bin: full range, small, correlated pair, lone channel or extremes.
    function automatic bin_word_t random_bin();
        int  lre, lim, rre, rim, k, kind;
        bit  last;
        kind = $urandom_range(0, 9);
        last = ($urandom_range(0, 15) == 0);
        lre  = rand_s16();
        lim  = rand_s16();
        rre  = rand_s16();
        rim  = rand_s16();
        case (kind)
            3, 4:
            begin
                lre = rand_near(300); lim = rand_near(300);
                rre = rand_near(300); rim = rand_near(300);
            end
            5, 6, 7:
            begin
                // Right is a scaled, slightly rotated copy of left, sign either way.
                k   = rand_near(24);
                rre = (lre * k) / 16 + rand_near(64) - (lim / 32);
                rim = (lim * k) / 16 + rand_near(64) + (lre / 32);
                if (rre > 32767)  rre = 32767;
                if (rre < -32768) rre = -32768;
                if (rim > 32767)  rim = 32767;
                if (rim < -32768) rim = -32768;
            end
            8:
            begin
                if ($urandom_range(0, 1))
                begin
                    lre = 0; lim = 0;
                end
                else
                begin
                    rre = rand_near(2); rim = rand_near(2);
                end
            end
            9:
            begin
                lre = pick_extreme(); lim = pick_extreme();
                rre = pick_extreme(); rim = pick_extreme();
            end
            default: ;
        endcase
        return make_bin(lre, lim, rre, rim, last);
    endfunction

    initial
    begin
        // Directed: silence, lone channels, full pans, cancellation, extremes.
        enqueue_bin(make_bin(0, 0, 0, 0, 0));
        enqueue_bin(make_bin(0, 0, 100, 0, 0));
        enqueue_bin(make_bin(100, 0, 0, 0, 1));
        enqueue_bin(make_bin(0, 0, 0, -32768, 0));
        enqueue_bin(make_bin(5, 0, -5, 0, 0));
        enqueue_bin(make_bin(-32768, -32768, 32767, 32767, 0));
        enqueue_bin(make_bin(-32768, -32768, -32768, -32768, 1));
        enqueue_bin(make_bin(32767, 32767, 32767, 32767, 0));
        enqueue_bin(make_bin(32767, -32768, -32768, 32767, 0));
        enqueue_bin(make_bin(-32768, 0, 0, -32768, 0));
        enqueue_bin(make_bin(100, 0, 90, 0, 0));
        enqueue_bin(make_bin(90, 0, 100, 0, 0));
        enqueue_bin(make_bin(100, 0, 0, 100, 1));
        enqueue_bin(make_bin(1000, 200, -900, -150, 0));
        enqueue_bin(make_bin(-900, -150, 1000, 200, 0));
        enqueue_bin(make_bin(1, 0, 0, 1, 0));
        enqueue_bin(make_bin(-1, -1, 1, 1, 0));
        enqueue_bin(make_bin(300, 400, 400, 300, 0));
        enqueue_bin(make_bin(32767, 0, 1, 0, 0));
        enqueue_bin(make_bin(1, 0, 32767, 0, 1));
        for (int i = 0; i < N_RANDOM; i++)
            enqueue_bin(random_bin());
    end

    // ------------------------------------------------------------------
    // Reset and idle values
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        bin_ch.valid    = 1'b0;
        bin_ch.left_re  = '0;
        bin_ch.left_im  = '0;
        bin_ch.right_re = '0;
        bin_ch.right_im = '0;
        bin_ch.last_bin = 1'b0;
        est_ch.ready    = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge, one word per handshake
    // ------------------------------------------------------------------

    int send_gap = 0;

    always @(negedge clk)
    begin
        bin_word_t b;
        if (rst_n)
        begin
            if (bin_fire || !bin_ch.valid)
            begin
                // Previous word is gone (or none was offered): idle or advance.
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    bin_ch.valid <= 1'b0;
                end
                else if (pending_bins.size() > 0)
                begin
                    b = pending_bins.pop_front();
                    bin_ch.valid    <= 1'b1;
                    bin_ch.left_re  <= b.left_re;
                    bin_ch.left_im  <= b.left_im;
                    bin_ch.right_re <= b.right_re;
                    bin_ch.right_im <= b.right_im;
                    bin_ch.last_bin <= b.last_bin;
                    // Start an idle burst now and then, never in the calm tail.
                    if (pending_bins.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 7);
                end
                else
                    bin_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink ready: random bursts of backpressure plus one long hold
    // ------------------------------------------------------------------

    int sink_gap = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                est_ch.ready <= 1'b0;
            end
            else if (pending_bins.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
            begin
                sink_gap <= $urandom_range(0, 6);
                est_ch.ready <= 1'b0;
            end
            else
                est_ch.ready <= !long_hold;
        end
    end

    // Hold the sink off long enough for the pipeline to fill and stall the input.
    initial
    begin
        wait (n_accepted >= STALL_AFTER);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        long_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then record accepted bins, on the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        est_word_t e;
        bin_word_t b;
        bin_fire <= rst_n && bin_ch.valid && bin_ch.ready;
        if (rst_n)
        begin
            if (est_ch.valid && est_ch.ready)
            begin
                if (expected_ests.size() == 0)
                begin
                    $error("estimate word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_ests.pop_front();
                    if (est_ch.pan !== e.pan)
                    begin
                        $error("pan: expected %0d, got %0d", e.pan, est_ch.pan);
                        errors++;
                    end
                    if (est_ch.pan_amp !== e.pan_amp)
                    begin
                        $error("pan_amp: expected %0d, got %0d", e.pan_amp, est_ch.pan_amp);
                        errors++;
                    end
                    if (est_ch.power_left !== e.power_left)
                    begin
                        $error("power_left: expected %0d, got %0d",
                               e.power_left, est_ch.power_left);
                        errors++;
                    end
                    if (est_ch.power_right !== e.power_right)
                    begin
                        $error("power_right: expected %0d, got %0d",
                               e.power_right, est_ch.power_right);
                        errors++;
                    end
                    if (est_ch.last_out !== e.last_out)
                    begin
                        $error("last_out: expected %0b, got %0b", e.last_out, est_ch.last_out);
                        errors++;
                    end
                end
            end
            if (bin_ch.valid && bin_ch.ready)
            begin
                b.left_re  = bin_ch.left_re;
                b.left_im  = bin_ch.left_im;
                b.right_re = bin_ch.right_re;
                b.right_im = bin_ch.right_im;
                b.last_bin = bin_ch.last_bin;
                expected_ests = {expected_ests, predict_estimate(b)};
                n_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------

    initial
    begin
        @(posedge rst_n);
        // Drain: all bins sent, then every expected estimate seen.
        while (pending_bins.size() > 0 || bin_ch.valid)
            @(posedge clk);
        while (expected_ests.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (errors == 0 && expected_ests.size() == 0)
            $display("** stereo_bin_pan_estimator: PASSED **");
        else
            $display("** stereo_bin_pan_estimator: FAILED **");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("** stereo_bin_pan_estimator: FAILED **");
        $finish;
    end

endmodule
